/* rtl/core/bpsfu_pkg.sv */
// Package for the pixel store with 2x2 triangle upsampling.
// Holds the payload structs, configuration struct, state codes and helpers.
// No dependencies.
`timescale 1ns / 1ps

package bpsfu_pkg;

  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned MaxHeightDef = 256;
  localparam int unsigned TileEdge     = 10;

  // coordinates stay below 1024 since the size registers are 9 bits wide
  localparam int unsigned CoordW   = 11;
  localparam int unsigned TileAW   = 7;
  localparam int unsigned SampAW   = 6;
  localparam int unsigned CfgAddrW = 4;

  localparam logic [15:0] PixelReset = 16'(128 << 4);

  localparam logic       ModeWrite  = 1'b0;
  localparam logic       ModeRead   = 1'b1;
  localparam logic [5:0] LastSample = 6'd63;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegMode   = 2'd2;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic       mode;
    logic [4:0] block_col;
    logic [4:0] block_row;
    logic [5:0] sample_index;
    logic [7:0] sample_value;
    logic [7:0] pixel_col;
    logic [7:0] pixel_row;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic [7:0]  pixel_byte;
    logic        block_done;
  } out_item_t;

  typedef struct packed {
    logic [8:0] image_width;
    logic [8:0] image_height;
    logic       subsample_mode;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EMIT,
    ST_FULL_RD,
    ST_FULL_WR,
    ST_TILE_RD,
    ST_TILE_WR,
    ST_TILE_INV,
    ST_UP
  } state_e;

  typedef enum logic {
    SRC_SAMPLE,
    SRC_TILE
  } src_e;

  function automatic logic [TileAW-1:0] tile_idx(logic [3:0] r, logic [3:0] c);
    return TileAW'({r, 3'b000}) + TileAW'({r, 1'b0}) + TileAW'(c);
  endfunction

  function automatic logic [19:0] pix_offset(coord_t x, coord_t y, coord_t w);
    logic [19:0] p;
    p = {10'b0, y[9:0]} * {10'b0, w[9:0]};
    return p + 20'(x[9:0]);
  endfunction

endpackage

/* rtl/core/bpsfu_cfg.sv */
// Configuration registers behind the APB-style port.
// Depends on bpsfu_pkg.
`timescale 1ns / 1ps

module bpsfu_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpsfu_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output bpsfu_pkg::cfg_t                cfg_o
);

  bpsfu_pkg::cfg_t cfg_q, cfg_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        bpsfu_pkg::RegWidth:  cfg_d.image_width    = pwdata[8:0];
        bpsfu_pkg::RegHeight: cfg_d.image_height   = pwdata[8:0];
        bpsfu_pkg::RegMode:   cfg_d.subsample_mode = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bpsfu_pkg::RegWidth:  prdata = {23'b0, cfg_q.image_width};
      bpsfu_pkg::RegHeight: prdata = {23'b0, cfg_q.image_height};
      bpsfu_pkg::RegMode:   prdata = {31'b0, cfg_q.subsample_mode};
      default:              prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width    <= 9'd256;
      cfg_q.image_height   <= 9'd256;
      cfg_q.subsample_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/bpsfu_seq.sv */
// Sequencer around the pixel store, sample buffer and subsampled tile memories.
// Runs reads, block commits, tile rebuild and triangle upsampling. Depends on bpsfu_pkg.
`timescale 1ns / 1ps

module bpsfu_seq #(
  parameter int unsigned MAX_WIDTH  = bpsfu_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = bpsfu_pkg::MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpsfu_pkg::cfg_t     cfg_i,
  input  logic                in_valid_i,
  input  bpsfu_pkg::in_item_t in_data_i,
  output logic                in_stall_o,
  input  logic                out_free_i,
  output bpsfu_pkg::res_t     res_o
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned TileN = bpsfu_pkg::TileEdge * bpsfu_pkg::TileEdge;

  localparam bpsfu_pkg::coord_t CoordOne  = bpsfu_pkg::coord_t'(1);
  localparam bpsfu_pkg::coord_t CoordTwo  = bpsfu_pkg::coord_t'(2);
  localparam bpsfu_pkg::coord_t CoordSpan = bpsfu_pkg::coord_t'(16);

  typedef logic signed [21:0] acc_t;

  // memories
  logic [15:0] pix_mem  [Depth];
  logic [7:0]  samp_mem [64];
  logic [15:0] tile_mem [TileN];

  logic [15:0] pix_rd_q, tile_rd_q;
  logic [7:0]  samp_rd_q;

  logic                              pix_re, pix_we, samp_re, samp_we, tile_re, tile_we;
  logic [AW-1:0]                     pix_raddr, pix_waddr;
  logic [15:0]                       pix_wd, tile_wd;
  logic [bpsfu_pkg::SampAW-1:0]      samp_raddr;
  logic [bpsfu_pkg::TileAW-1:0]      tile_raddr, tile_waddr;
  bpsfu_pkg::coord_t                 rd_x, rd_y, wr_x, wr_y;

  // control state
  bpsfu_pkg::state_e state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [4:0]        bc_q, bc_d, br_q, br_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [3:0]        ti_q, ti_d, tj_q, tj_d;
  logic [2:0]        sub_q, sub_d;
  bpsfu_pkg::coord_t x_q, x_d, y_q, y_d;
  acc_t              acc_q, acc_d;
  logic              done_q, done_d, par_q, par_d;
  bpsfu_pkg::src_e   src_q, src_d;

  bpsfu_pkg::coord_t w, h, bx0, by0, x0, y0, x1, y1;
  bpsfu_pkg::coord_t xmin, xmax, ymin, ymax, in_bx0, in_by0, sat_x, sat_y;
  logic [3:0]        tr, tc, trn, tcn, tile_r, tile_c;
  logic [bpsfu_pkg::TileAW-1:0] k;
  acc_t              pix_ext, tile_ext, inv_term, up_term, acc_sum;
  logic [16:0]       dither;
  logic              accept, tile_last;

  // effective image size
  always_comb begin
    if (cfg_i.image_width == 9'd0) begin
      w = bpsfu_pkg::coord_t'(1);
    end else if (int'(cfg_i.image_width) > int'(MAX_WIDTH)) begin
      w = bpsfu_pkg::coord_t'(MAX_WIDTH);
    end else begin
      w = bpsfu_pkg::coord_t'(cfg_i.image_width);
    end
    if (cfg_i.image_height == 9'd0) begin
      h = bpsfu_pkg::coord_t'(1);
    end else if (int'(cfg_i.image_height) > int'(MAX_HEIGHT)) begin
      h = bpsfu_pkg::coord_t'(MAX_HEIGHT);
    end else begin
      h = bpsfu_pkg::coord_t'(cfg_i.image_height);
    end
  end

  assign bx0    = bpsfu_pkg::coord_t'({bc_q, 4'b0000});
  assign by0    = bpsfu_pkg::coord_t'({br_q, 4'b0000});
  assign in_bx0 = bpsfu_pkg::coord_t'({in_data_i.block_col, 4'b0000});
  assign in_by0 = bpsfu_pkg::coord_t'({in_data_i.block_row, 4'b0000});

  // read coordinates saturate to the last column and row
  always_comb begin
    sat_x = bpsfu_pkg::coord_t'(in_data_i.pixel_col);
    sat_y = bpsfu_pkg::coord_t'(in_data_i.pixel_row);
    if (sat_x > w - CoordOne) sat_x = w - CoordOne;
    if (sat_y > h - CoordOne) sat_y = h - CoordOne;
  end

  // tile entry: rows 1..9 then row 0, columns likewise
  assign tile_r = (tj_q == 4'd9) ? 4'd0 : tj_q + 4'd1;
  assign tile_c = (ti_q == 4'd9) ? 4'd0 : ti_q + 4'd1;
  assign x0 = (ti_q == 4'd9) ? bx0 - CoordTwo : bx0 + bpsfu_pkg::coord_t'({ti_q, 1'b0});
  assign y0 = (tj_q == 4'd9) ? by0 - CoordTwo : by0 + bpsfu_pkg::coord_t'({tj_q, 1'b0});
  assign x1 = (x0 > 0) ? x0 - CoordOne : '0;
  assign y1 = (y0 > 0) ? y0 - CoordOne : '0;
  assign k  = bpsfu_pkg::tile_idx(tile_r, tile_c);
  assign tile_last = (ti_q == 4'd9) && (tj_q == 4'd9);

  // upsampling window around the block, clipped to the image
  always_comb begin
    xmin = (bx0 - CoordOne > 0) ? bx0 - CoordOne : '0;
    ymin = (by0 - CoordOne > 0) ? by0 - CoordOne : '0;
    xmax = (bx0 + CoordSpan < w - CoordOne) ? bx0 + CoordSpan : w - CoordOne;
    ymax = (by0 + CoordSpan < h - CoordOne) ? by0 + CoordSpan : h - CoordOne;
  end

  assign tr  = 4'((y_q >>> 1) - bpsfu_pkg::coord_t'({br_q, 3'b000}) + 1);
  assign tc  = 4'((x_q >>> 1) - bpsfu_pkg::coord_t'({bc_q, 3'b000}) + 1);
  assign trn = y_q[0] ? tr + 4'd1 : tr - 4'd1;
  assign tcn = x_q[0] ? tc + 4'd1 : tc - 4'd1;

  // weighted terms of the two filters
  assign pix_ext  = acc_t'({6'b0, pix_rd_q});
  assign tile_ext = acc_t'({6'b0, tile_rd_q});

  always_comb begin
    case (sub_q)
      3'd1:    inv_term = (pix_ext <<< 3) + pix_ext;
      3'd2:    inv_term = pix_ext;
      default: inv_term = -((pix_ext <<< 1) + pix_ext);
    endcase
    case (sub_q)
      3'd1:    up_term = (tile_ext <<< 3) + tile_ext;
      3'd4:    up_term = tile_ext;
      default: up_term = (tile_ext <<< 1) + tile_ext;
    endcase
  end

  assign dither = {1'b0, pix_rd_q} + 17'd8 - 17'(par_q);
  assign accept = in_valid_i && (state_q == bpsfu_pkg::ST_IDLE);
  assign in_stall_o = (state_q != bpsfu_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    bc_d    = bc_q;
    br_d    = br_q;
    cnt_d   = cnt_q;
    ti_d    = ti_q;
    tj_d    = tj_q;
    sub_d   = sub_q;
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    done_d  = done_q;
    par_d   = par_q;
    src_d   = src_q;
    acc_sum = '0;

    pix_re     = 1'b0;
    pix_we     = 1'b0;
    samp_re    = 1'b0;
    samp_we    = 1'b0;
    tile_re    = 1'b0;
    tile_we    = 1'b0;
    rd_x       = '0;
    rd_y       = '0;
    wr_x       = '0;
    wr_y       = '0;
    pix_wd     = bpsfu_pkg::PixelReset;
    samp_raddr = '0;
    tile_raddr = '0;
    tile_waddr = k;
    tile_wd    = '0;

    res_o.valid = 1'b0;
    res_o.item  = '0;

    case (state_q)
      bpsfu_pkg::ST_CLEAR: begin
        pix_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == AW'(Depth - 1)) state_d = bpsfu_pkg::ST_IDLE;
      end

      bpsfu_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data_i.mode == bpsfu_pkg::ModeRead) begin
            pix_re  = 1'b1;
            rd_x    = sat_x;
            rd_y    = sat_y;
            par_d   = sat_x[0];
            done_d  = 1'b0;
            state_d = bpsfu_pkg::ST_EMIT;
          end else begin
            samp_we = 1'b1;
            if (in_data_i.sample_index == bpsfu_pkg::LastSample) begin
              bc_d   = in_data_i.block_col;
              br_d   = in_data_i.block_row;
              done_d = 1'b1;
              cnt_d  = '0;
              ti_d   = '0;
              tj_d   = '0;
              if (!cfg_i.subsample_mode) begin
                state_d = bpsfu_pkg::ST_FULL_RD;
              end else if (in_bx0 >= w || in_by0 >= h) begin
                state_d = bpsfu_pkg::ST_EMIT;
              end else begin
                state_d = bpsfu_pkg::ST_TILE_RD;
              end
            end
          end
        end
      end

      bpsfu_pkg::ST_EMIT: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          if (!done_q) begin
            res_o.item.pixel_value = pix_rd_q;
            res_o.item.pixel_byte  = dither[11:4];
          end
          res_o.item.block_done = done_q;
          state_d = bpsfu_pkg::ST_IDLE;
        end
      end

      bpsfu_pkg::ST_FULL_RD: begin
        samp_re    = 1'b1;
        samp_raddr = cnt_q;
        state_d    = bpsfu_pkg::ST_FULL_WR;
      end

      bpsfu_pkg::ST_FULL_WR: begin
        wr_x   = bpsfu_pkg::coord_t'({bc_q, cnt_q[2:0]});
        wr_y   = bpsfu_pkg::coord_t'({br_q, cnt_q[5:3]});
        pix_wd = {4'b0, samp_rd_q, 4'b0};
        // clip pixels beyond the image
        pix_we = (wr_x < w) && (wr_y < h);
        cnt_d  = cnt_q + 6'd1;
        state_d = (cnt_q == bpsfu_pkg::LastSample) ? bpsfu_pkg::ST_EMIT
                                                   : bpsfu_pkg::ST_FULL_RD;
      end

      bpsfu_pkg::ST_TILE_RD: begin
        src_d = bpsfu_pkg::SRC_TILE;
        state_d = bpsfu_pkg::ST_TILE_WR;
        // replicate the neighbour inside the tile at the image edges
        if (x0 < 0) begin
          tile_re    = 1'b1;
          tile_raddr = k + 7'd1;
        end else if (y0 < 0) begin
          tile_re    = 1'b1;
          tile_raddr = k + 7'd10;
        end else if (x0 >= w) begin
          tile_re    = 1'b1;
          tile_raddr = k - 7'd1;
        end else if (y0 >= h) begin
          tile_re    = 1'b1;
          tile_raddr = k - 7'd10;
        end else if (ti_q < 4'd8 && tj_q < 4'd8) begin
          samp_re    = 1'b1;
          samp_raddr = {tj_q[2:0], ti_q[2:0]};
          src_d      = bpsfu_pkg::SRC_SAMPLE;
        end else begin
          pix_re  = 1'b1;
          rd_x    = x0;
          rd_y    = y0;
          acc_d   = '0;
          sub_d   = 3'd1;
          state_d = bpsfu_pkg::ST_TILE_INV;
        end
      end

      bpsfu_pkg::ST_TILE_WR: begin
        tile_we = 1'b1;
        tile_wd = (src_q == bpsfu_pkg::SRC_TILE) ? tile_rd_q : {4'b0, samp_rd_q, 4'b0};
      end

      bpsfu_pkg::ST_TILE_INV: begin
        acc_sum = acc_q + inv_term;
        acc_d   = acc_sum;
        sub_d   = sub_q + 3'd1;
        case (sub_q)
          3'd1: begin
            pix_re = 1'b1;
            rd_x   = x1;
            rd_y   = y1;
          end
          3'd2: begin
            pix_re = 1'b1;
            rd_x   = x1;
            rd_y   = y0;
          end
          3'd3: begin
            pix_re = 1'b1;
            rd_x   = x0;
            rd_y   = y1;
          end
          default: begin
            // floor of the sum over four, wrapped to 16 bits
            tile_we = 1'b1;
            tile_wd = acc_sum[17:2];
          end
        endcase
      end

      bpsfu_pkg::ST_UP: begin
        tile_re = (sub_q != 3'd4);
        case (sub_q)
          3'd0:    tile_raddr = bpsfu_pkg::tile_idx(tr, tc);
          3'd1:    tile_raddr = bpsfu_pkg::tile_idx(trn, tc);
          3'd2:    tile_raddr = bpsfu_pkg::tile_idx(tr, tcn);
          default: tile_raddr = bpsfu_pkg::tile_idx(trn, tcn);
        endcase
        acc_sum = (sub_q == 3'd0) ? '0 : acc_q + up_term;
        acc_d   = acc_sum;
        sub_d   = sub_q + 3'd1;
        if (sub_q == 3'd4) begin
          pix_we = 1'b1;
          wr_x   = x_q;
          wr_y   = y_q;
          pix_wd = acc_sum[19:4];
          sub_d  = '0;
          if (x_q == xmax) begin
            x_d = xmin;
            y_d = y_q + CoordOne;
            if (y_q == ymax) state_d = bpsfu_pkg::ST_EMIT;
          end else begin
            x_d = x_q + CoordOne;
          end
        end
      end

      default: state_d = bpsfu_pkg::ST_IDLE;
    endcase

    // advance through the tile once its entry is written
    if (tile_we) begin
      if (tile_last) begin
        x_d     = xmin;
        y_d     = ymin;
        sub_d   = '0;
        state_d = bpsfu_pkg::ST_UP;
      end else begin
        state_d = bpsfu_pkg::ST_TILE_RD;
        if (ti_q == 4'd9) begin
          ti_d = '0;
          tj_d = tj_q + 4'd1;
        end else begin
          ti_d = ti_q + 4'd1;
        end
      end
    end
  end

  assign pix_raddr = AW'(bpsfu_pkg::pix_offset(rd_x, rd_y, w));
  assign pix_waddr = (state_q == bpsfu_pkg::ST_CLEAR) ? clr_q
                                                      : AW'(bpsfu_pkg::pix_offset(wr_x, wr_y, w));

  always_ff @(posedge clk_i) begin
    if (pix_we) pix_mem[pix_waddr] <= pix_wd;
    if (pix_re) pix_rd_q <= pix_mem[pix_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (samp_we) samp_mem[in_data_i.sample_index] <= in_data_i.sample_value;
    if (samp_re) samp_rd_q <= samp_mem[samp_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tile_we) tile_mem[tile_waddr] <= tile_wd;
    if (tile_re) tile_rd_q <= tile_mem[tile_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpsfu_pkg::ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      ti_q    <= '0;
      tj_q    <= '0;
      sub_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      ti_q    <= ti_d;
      tj_q    <= tj_d;
      sub_q   <= sub_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bc_q  <= bc_d;
    br_q  <= br_d;
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    par_q <= par_d;
    src_q <= src_d;
  end

endmodule

/* rtl/core/block_pixel_store_fancy_upsample_core.sv */
// Top level of the pixel store with 2x2 triangle upsampling.
// Reset starts a clearing pass over all MAX_WIDTH*MAX_HEIGHT pixels that sets every pixel
// to 2048; no item is taken until it ends. Pixel read: the memory read is registered, then
// the result passes through the output register. Sample write: into the sample buffer.
// Full-resolution commit: each sample is read, then written. 2x2 commit: tile entries are
// built, then up to 324 pixels rewritten, one read at a time on each memory's single port.
`timescale 1ns / 1ps

module block_pixel_store_fancy_upsample_core #(
  parameter int unsigned MAX_WIDTH  = bpsfu_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = bpsfu_pkg::MaxHeightDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bpsfu_pkg::in_item_t            in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bpsfu_pkg::out_item_t           out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpsfu_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  bpsfu_pkg::cfg_t      cfg;
  bpsfu_pkg::res_t      res;
  bpsfu_pkg::out_item_t out_data_q;
  logic                 out_valid_q, out_free;

  bpsfu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bpsfu_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .res_o      (res)
  );

  // output register: load a new result once the held one is transferred
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) out_data_q <= res.item;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> out_free)
    else $error("result loaded while output register held");

  a_commit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.block_done) |->
      (out_data_o.pixel_value == 16'd0 && out_data_o.pixel_byte == 8'd0))
    else $error("commit result carries pixel data");

  a_idle_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !res.valid)
    else $error("result emitted while taking input");

endmodule

/* tb/block_pixel_store_fancy_upsample_core_tb.sv */
// Testbench for the pixel store with 2x2 triangle upsampling.
// Drives sample writes and pixel reads under random idling, checks results against
// an in-bench pixel model; depends on bpsfu_pkg and the core top level only.
`timescale 1ns / 1ps

module block_pixel_store_fancy_upsample_core_tb;
  import bpsfu_pkg::*;

  localparam int StoreDepth = 65536;
  localparam int SettleCycles = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  block_pixel_store_fancy_upsample_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // pixel model state
  logic [15:0] pixels [StoreDepth];
  logic [7:0]  samples [64];
  logic [15:0] tile [100];
  logic [8:0]  width_reg = 9'd256;
  logic [8:0]  height_reg = 9'd256;
  logic        sub_reg = 1'b0;

  out_item_t   pending_q[$];
  int          fail_count = 0;
  bit          send_calm = 0;
  bit          recv_calm = 0;
  bit          hold_req = 0;
  bit          block_seen = 0;

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic int eff_dim(logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  function automatic logic [15:0] inverse_pixel(int x0, int y0, int w);
    int x1, y1, s;
    x1 = x0 > 0 ? x0 - 1 : 0;
    y1 = y0 > 0 ? y0 - 1 : 0;
    s = 9 * int'(pixels[y0*w+x0]) + int'(pixels[y1*w+x1])
        - 3 * int'(pixels[y0*w+x1]) - 3 * int'(pixels[y1*w+x0]);
    s = s >>> 2;
    return s[15:0];
  endfunction

  function automatic void commit_full(int bc, int br, int w, int h);
    int x, y;
    for (int iy = 0; iy < 8; iy++) begin
      for (int ix = 0; ix < 8; ix++) begin
        x = 8 * bc + ix;
        y = 8 * br + iy;
        if (x < w && y < h) pixels[y*w+x] = {4'b0, samples[iy*8+ix], 4'b0};
      end
    end
  endfunction

  function automatic void commit_tile(int bc, int br, int w, int h);
    int bx0, by0, r, c, x0, y0, k, xmin, xmax, ymin, ymax, ty, dy, tx, dx, s;
    logic [15:0] v;
    bx0 = bc * 16;
    by0 = br * 16;
    if (bx0 >= w || by0 >= h) return;
    // interior rows and columns first, then the leading border row and column
    for (int j = 0; j < 10; j++) begin
      r = j < 9 ? j + 1 : 0;
      y0 = by0 + (j < 9 ? j * 2 : -2);
      for (int i = 0; i < 10; i++) begin
        c = i < 9 ? i + 1 : 0;
        x0 = bx0 + (i < 9 ? i * 2 : -2);
        k = r * 10 + c;
        if (x0 < 0) v = tile[k+1];
        else if (y0 < 0) v = tile[k+10];
        else if (x0 >= w) v = tile[k-1];
        else if (y0 >= h) v = tile[k-10];
        else if (i < 8 && j < 8) v = {4'b0, samples[j*8+i], 4'b0};
        else v = inverse_pixel(x0, y0, w);
        tile[k] = v;
      end
    end
    xmin = bx0 - 1 > 0 ? bx0 - 1 : 0;
    xmax = bx0 + 16 < w - 1 ? bx0 + 16 : w - 1;
    ymin = by0 - 1 > 0 ? by0 - 1 : 0;
    ymax = by0 + 16 < h - 1 ? by0 + 16 : h - 1;
    for (int y = ymin; y <= ymax; y++) begin
      ty = ((y >> 1) - br * 8 + 1) * 10;
      dy = (y & 1) ? 10 : -10;
      for (int x = xmin; x <= xmax; x++) begin
        tx = (x >> 1) - bc * 8 + 1;
        dx = (x & 1) ? 1 : -1;
        k = ty + tx;
        s = 9 * int'(tile[k]) + 3 * int'(tile[k+dy]) + 3 * int'(tile[k+dx])
            + int'(tile[k+dx+dy]);
        pixels[y*w+x] = s[19:4];
      end
    end
  endfunction

  function automatic bit pixel_step(in_item_t it, output out_item_t res);
    int w, h, x, y, v;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    res = '0;
    if (it.mode == ModeRead) begin
      x = it.pixel_col > w - 1 ? w - 1 : it.pixel_col;
      y = it.pixel_row > h - 1 ? h - 1 : it.pixel_row;
      v = pixels[y*w+x];
      res.pixel_value = v[15:0];
      res.pixel_byte = 8'((v + 8 - (x & 1)) >> 4);
      return 1;
    end
    samples[it.sample_index] = it.sample_value;
    if (it.sample_index != LastSample) return 0;
    if (sub_reg) commit_tile(it.block_col, it.block_row, w, h);
    else commit_full(it.block_col, it.block_row, w, h);
    res.block_done = 1'b1;
    return 1;
  endfunction

  function automatic int pick_gap(bit calm);
    if (calm) return 0;
    return $urandom_range(0, 12);
  endfunction

  // queues the model result; a typed expectation overrides it where given
  task automatic send(in_item_t it, bit typed = 0, out_item_t want = '0);
    int gap;
    out_item_t res;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (pixel_step(it, res)) pending_q.push_back(typed ? want : res);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CfgAddrW'({idx, 2'b00});
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegWidth:  width_reg = val;
      RegHeight: height_reg = val;
      RegMode:   sub_reg = val[0];
      default: ;
    endcase
  endtask

  function automatic in_item_t read_item(int col, int row);
    in_item_t it;
    it = in_item_t'($urandom());
    it.mode = ModeRead;
    it.pixel_col = 8'(col);
    it.pixel_row = 8'(row);
    return it;
  endfunction

  function automatic in_item_t write_item(int bc, int br, int idx, int val);
    in_item_t it;
    it = in_item_t'($urandom());
    it.mode = ModeWrite;
    it.block_col = 5'(bc);
    it.block_row = 5'(br);
    it.sample_index = 6'(idx);
    it.sample_value = 8'(val);
    return it;
  endfunction

  // well-formed blocks with random content, stray reads, and noise bursts
  task automatic random_phase(int count);
    int w, h, span, bc, br, sent;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    span = sub_reg ? 16 : 8;
    sent = 0;
    while (sent < count) begin
      if (!block_seen || $urandom_range(0, 3) != 0) begin
        bc = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, (w-1)/span);
        br = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, (h-1)/span);
        for (int idx = 0; idx < 64; idx++) begin
          send(write_item(bc, br, idx, $urandom_range(0, 255)));
          sent++;
          if ($urandom_range(0, 7) == 0) begin
            send(read_item($urandom_range(0, 255), $urandom_range(0, 255)));
            sent++;
          end
        end
        block_seen = 1;
        for (int n = $urandom_range(2, 8); n > 0; n--) begin
          send(read_item(bc * span + $urandom_range(0, span + 1) - 1,
                         br * span + $urandom_range(0, span + 1) - 1));
          sent++;
        end
      end else begin
        for (int n = $urandom_range(4, 12); n > 0; n--) begin
          if ($urandom_range(0, 1) == 0)
            send(read_item($urandom_range(0, 255), $urandom_range(0, 255)));
          else
            send(write_item($urandom_range(0, 31), $urandom_range(0, 31),
                            $urandom_range(0, 63), $urandom_range(0, 255)));
          sent++;
        end
      end
    end
  endtask

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    for (int k = 0; k < StoreDepth; k++) pixels[k] = PixelReset;
    // reset pixels read back as 2048 with byte 128 at either column parity
    rows.push_back('{read_item(0, 0), 1, '{16'd2048, 8'd128, 1'b0}});
    rows.push_back('{read_item(255, 255), 1, '{16'd2048, 8'd128, 1'b0}});
    rows.push_back('{read_item(1, 0), 1, '{16'd2048, 8'd128, 1'b0}});
    rows.push_back('{read_item(0, 255), 1, '{16'd2048, 8'd128, 1'b0}});
    rows.push_back('{read_item(255, 0), 1, '{16'd2048, 8'd128, 1'b0}});
    rows.push_back('{write_item(0, 0, 0, 0), 0, '0});
    rows.push_back('{write_item(31, 31, 62, 255), 0, '0});
    rows.push_back('{write_item(31, 0, 1, 255), 0, '0});
    rows.push_back('{write_item(0, 31, 32, 0), 0, '0});
    rows.push_back('{write_item(21, 10, 42, 170), 0, '0});
    rows.push_back('{write_item(10, 21, 21, 85), 0, '0});
    rows.push_back('{read_item(170, 85), 0, '0});
    rows.push_back('{read_item(85, 170), 0, '0});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].want);

    hold_req = 1;
    random_phase(240);
    drain_results();

    write_reg(RegMode, 9'd1);
    random_phase(260);
    drain_results();

    // zero sizes act as one pixel
    write_reg(RegWidth, 9'd0);
    write_reg(RegHeight, 9'd0);
    random_phase(150);
    drain_results();

    // oversized registers clamp to the maximum
    write_reg(RegWidth, 9'd511);
    write_reg(RegHeight, 9'd511);
    write_reg(RegMode, 9'd0);
    random_phase(200);
    drain_results();

    write_reg(RegWidth, 9'd37);
    write_reg(RegHeight, 9'd50);
    write_reg(RegMode, 9'd1);
    random_phase(250);
    drain_results();

    write_reg(RegWidth, 9'd256);
    write_reg(RegHeight, 9'd1);
    random_phase(150);
    drain_results();

    write_reg(RegWidth, 9'd1);
    write_reg(RegHeight, 9'd256);
    random_phase(150);
    drain_results();

    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (2500) @(posedge clk_i);
        hold_req = 0;
      end
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      n = pick_gap(recv_calm);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && !hold_req);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        report("unexpected transfer", 1, 0);
      end else begin
        want = pending_q.pop_front();
        if (out_data_o.pixel_value != want.pixel_value)
          report("pixel_value", out_data_o.pixel_value, want.pixel_value);
        if (out_data_o.pixel_byte != want.pixel_byte)
          report("pixel_byte", out_data_o.pixel_byte, want.pixel_byte);
        if (out_data_o.block_done != want.block_done)
          report("block_done", out_data_o.block_done, want.block_done);
      end
    end
  end

  initial begin
    #100ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
